// ===== hdl/rme_pkg.sv =====
// Shared constants and types for the modular exponentiation block.
// No dependencies; imported by rme_mulmod and rsa_modular_exponentiation.
package rme_pkg;

    localparam int WORD_BITS_DEF = 64;
    localparam int CFG_IDX_BITS  = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_MODULUS     = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PUBLIC_EXP  = 8'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_PRIVATE_EXP = 8'd2;

    // command from the sequencer to the multiplier unit
    typedef struct packed {
        logic start;
        logic reduce;   // 1: x mod m (MSB first), 0: x*y mod m (LSB first)
    } t_mm_cmd;

endpackage

// ===== hdl/rme_addmod.sv =====
// Modular adder: (a + b + cin) mod m for a, b < m, single conditional subtract.
// Depends on nothing; used by rme_mulmod.
module rme_addmod #(
    parameter int W = 64
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic         i_cin,
    input  logic [W-1:0] i_m,
    output logic [W-1:0] o_sum
);

    logic [W:0] w_sum;
    logic [W:0] w_diff;

    assign w_sum  = {1'b0, i_a} + {1'b0, i_b} + {{W{1'b0}}, i_cin};
    assign w_diff = w_sum - {1'b0, i_m};
    // borrow out means the sum was already below m
    assign o_sum  = w_diff[W] ? w_sum[W-1:0] : w_diff[W-1:0];

endmodule

// ===== hdl/rme_mulmod.sv =====
// Bit-serial modular multiply / reduce unit, one operand bit per cycle.
// Depends on rme_pkg (t_mm_cmd) and rme_addmod.
module rme_mulmod
    import rme_pkg::*;
#(
    parameter int W = WORD_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_mm_cmd      i_cmd,
    input  logic [W-1:0] i_x,
    input  logic [W-1:0] i_y,
    input  logic [W-1:0] i_m,
    output logic         o_done,
    output logic [W-1:0] o_res
);

    localparam int CW = $clog2(W);
    localparam logic [CW-1:0] LAST = CW'(W - 1);

    logic          r_busy;
    logic          r_done;
    logic          r_reduce;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_x;
    logic [W-1:0]  r_acc;
    logic [W-1:0]  r_add;

    logic [W-1:0]  w_acc_sum;
    logic [W-1:0]  w_dbl;

    rme_addmod #(.W(W)) u_add_acc (
        .i_a   (r_acc),
        .i_b   (r_add),
        .i_cin (1'b0),
        .i_m   (i_m),
        .o_sum (w_acc_sum)
    );

    // doubling lane; in reduce mode it shifts in the next dividend bit
    rme_addmod #(.W(W)) u_add_dbl (
        .i_a   (r_add),
        .i_b   (r_add),
        .i_cin (r_reduce & r_x[W-1]),
        .i_m   (i_m),
        .o_sum (w_dbl)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == LAST) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_reduce <= i_cmd.reduce;
            r_cnt    <= '0;
            r_x      <= i_x;
            r_acc    <= '0;
            r_add    <= i_cmd.reduce ? '0 : i_y;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            r_add <= w_dbl;
            if (r_reduce) begin
                r_x <= {r_x[W-2:0], 1'b0};
            end else begin
                r_x <= {1'b0, r_x[W-1:1]};
                if (r_x[0]) begin
                    r_acc <= w_acc_sum;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_reduce ? r_add : r_acc;

endmodule

// ===== hdl/rsa_modular_exponentiation.sv =====
// Modular exponentiation block: result = value^e mod n (action 0) or value^d mod n (action 1).
// Takes one word at a time; o_ready is low while a word is being worked on. The value is first
// reduced mod n, then right-to-left square-and-multiply runs on one shared bit-serial multiplier.
// Exponent bits above the highest set bit cost nothing, so a word takes
// 1 + popcount(exp) + msb_index(exp) modular products. A modulus below two gives 0.
// The configuration port never stalls; write it only while the block is idle.
// Depends on rme_pkg and rme_mulmod.
module rsa_modular_exponentiation
    import rme_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration write channel
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [WORD_BITS-1:0]    i_cfg_data,
    // input words
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_action,
    input  logic [WORD_BITS-1:0]    i_value,
    // result words
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [WORD_BITS-1:0]    o_result
);

    localparam int W = WORD_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RED  = 3'd1;
    localparam logic [2:0] S_NEXT = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_SQR  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]   r_state, n_state;
    logic [W-1:0] r_mod;
    logic [W-1:0] r_pub;
    logic [W-1:0] r_priv;
    logic [W-1:0] r_exp, n_exp;
    logic [W-1:0] r_acc, n_acc;
    logic [W-1:0] r_sq, n_sq;
    logic [W-1:0] r_result;
    logic         r_out_valid;

    t_mm_cmd      w_cmd;
    logic [W-1:0] w_x;
    logic         w_mm_done;
    logic [W-1:0] w_mm_res;
    logic         w_accept;
    logic         w_mod_ok;
    logic         w_load_out;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == S_IDLE);
    assign w_accept    = i_valid && o_ready;
    assign w_mod_ok    = (r_mod[W-1:1] != '0);
    assign w_load_out  = (r_state == S_DONE) && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod  <= W'(2);
            r_pub  <= W'(1);
            r_priv <= W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MODULUS:     r_mod  <= i_cfg_data;
                REG_PUBLIC_EXP:  r_pub  <= i_cfg_data;
                REG_PRIVATE_EXP: r_priv <= i_cfg_data;
                default:         ;
            endcase
        end
    end

    // multiplier operands: the raw value on accept, else acc or sq by the exponent bit
    assign w_x        = (r_state == S_IDLE) ? i_value : (r_exp[0] ? r_acc : r_sq);
    assign w_cmd.start  = (w_accept && w_mod_ok) || (r_state == S_NEXT && r_exp != '0);
    assign w_cmd.reduce = (r_state == S_IDLE);

    rme_mulmod #(.W(W)) u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_x     (w_x),
        .i_y     (r_sq),
        .i_m     (r_mod),
        .o_done  (w_mm_done),
        .o_res   (w_mm_res)
    );

    always_comb begin
        n_state = r_state;
        n_exp   = r_exp;
        n_acc   = r_acc;
        n_sq    = r_sq;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_exp = i_action ? r_priv : r_pub;
                    if (w_mod_ok) begin
                        n_acc   = W'(1);
                        n_state = S_RED;
                    end else begin
                        n_acc   = '0;
                        n_state = S_DONE;
                    end
                end
            end
            S_RED: begin
                if (w_mm_done) begin
                    n_sq    = w_mm_res;
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                if (r_exp == '0) begin
                    n_state = S_DONE;
                end else if (r_exp[0]) begin
                    n_state = S_MUL;
                end else begin
                    n_state = S_SQR;
                end
            end
            S_MUL: begin
                if (w_mm_done) begin
                    n_acc   = w_mm_res;
                    n_exp   = {r_exp[W-1:1], 1'b0};
                    n_state = S_NEXT;
                end
            end
            S_SQR: begin
                if (w_mm_done) begin
                    n_sq    = w_mm_res;
                    n_exp   = {1'b0, r_exp[W-1:1]};
                    n_state = S_NEXT;
                end
            end
            S_DONE: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_exp <= n_exp;
        r_acc <= n_acc;
        r_sq  <= n_sq;
        if (w_load_out) begin
            r_result <= r_acc;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

endmodule
